### rtl/smf_pkg.sv
package smf_pkg;

  // Default queue depth
  localparam int unsigned SmfDepth = 64;

  // Request codes
  typedef logic [1:0] req_t;
  localparam req_t REQ_ENQ  = 2'd0;
  localparam req_t REQ_DEQ  = 2'd1;
  localparam req_t REQ_SRCH = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // Search token walking down the cell chain
  typedef struct packed {
    logic       vld;
    logic       found;
    logic [7:0] src;
  } tok_t;

endpackage

### rtl/smf_cell.sv
// One queue slot. Slot 0 is the head; a dequeue moves every slot one step
// toward the head. A search token passes through one slot per cycle.
module smf_cell import smf_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               wr_i,
  input  logic               shift_i,
  input  logic [7:0]         wr_src_i,
  input  logic signed [31:0] wr_mesg_i,
  input  logic [7:0]         nxt_src_i,
  input  logic signed [31:0] nxt_mesg_i,
  input  logic signed [31:0] key_i,
  input  tok_t               tok_i,
  output logic [7:0]         src_o,
  output logic signed [31:0] mesg_o,
  output tok_t               tok_o
);

  logic [7:0]         src_q, src_d;
  logic signed [31:0] mesg_q, mesg_d;
  tok_t               tok_q, tok_d;
  logic               occupied;
  logic               wr_here;

  assign occupied = count_i > CNT_W'(IDX);
  assign wr_here  = wr_i && (count_i == CNT_W'(IDX));

  // Slot contents: load on enqueue at the tail, take neighbor on dequeue
  always_comb begin
    src_d  = src_q;
    mesg_d = mesg_q;
    if (wr_here) begin
      src_d  = wr_src_i;
      mesg_d = wr_mesg_i;
    end else if (shift_i) begin
      src_d  = nxt_src_i;
      mesg_d = nxt_mesg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    mesg_q <= mesg_d;
  end

  // Token: first occupied slot with a matching payload claims it
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.found && occupied && (mesg_q == key_i)) begin
      tok_d.found = 1'b1;
      tok_d.src   = src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign src_o  = src_q;
  assign mesg_o = mesg_q;
  assign tok_o  = tok_q;

endmodule

### rtl/searchable_message_fifo_core.sv
// Message FIFO of DEPTH words (8-bit sender, signed 32-bit payload) kept in
// a chain of slots with the head in slot 0. Enqueue, dequeue and the unused
// request code load the result register at the accepting edge, so the result
// is offered in the next cycle. A search latches its key at the accepting
// edge; a token enters slot 0 in the next cycle, walks the slot chain one
// slot per cycle, compares each slot with the key and picks up the sender
// of the first matching message; the result is written at the edge after the
// token leaves the last slot. One request is in flight at a time; the next is
// taken as soon as the result register is empty or being drained. An enqueue
// to a full queue is dropped and flagged; occupancy is reported with every
// result.
module searchable_message_fifo_core import smf_pkg::*; #(
  parameter int unsigned DEPTH = SmfDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [7:0]                   in_src_i,
  input  logic signed [31:0]           in_mesg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [7:0]                   out_src_o,
  output logic signed [31:0]           out_mesg_o,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SRCH = 2'b10
  } state_e;

  state_e             st_q, st_d;
  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] key_q;
  logic               launch_q;
  logic               out_vld_q, out_vld_d;
  status_t            status_q, status_d;
  logic [7:0]         osrc_q, osrc_d;
  logic signed [31:0] omesg_q, omesg_d;

  logic               in_acc;
  logic               full, empty;
  logic               do_enq, do_deq;

  logic [7:0]         cell_src  [DEPTH];
  logic signed [31:0] cell_mesg [DEPTH];
  tok_t               tok       [DEPTH+1];

  assign full   = count_q == CntW'(DEPTH);
  assign empty  = count_q == '0;
  assign in_ready_o = (st_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign in_acc = in_valid_i && in_ready_o;
  assign do_enq = in_acc && (req_type_i == REQ_ENQ) && !full;
  assign do_deq = in_acc && (req_type_i == REQ_DEQ) && !empty;

  // Token enters slot 0 the cycle after the key is latched
  assign tok[0] = '{vld: launch_q, found: 1'b0, src: 8'd0};

  // Slot chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0]         nxt_src;
    logic signed [31:0] nxt_mesg;
    if (i == DEPTH - 1) begin : g_last
      assign nxt_src  = 8'd0;
      assign nxt_mesg = 32'sd0;
    end else begin : g_mid
      assign nxt_src  = cell_src[i+1];
      assign nxt_mesg = cell_mesg[i+1];
    end
    smf_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .wr_i       (do_enq),
      .shift_i    (do_deq),
      .wr_src_i   (in_src_i),
      .wr_mesg_i  (in_mesg_i),
      .nxt_src_i  (nxt_src),
      .nxt_mesg_i (nxt_mesg),
      .key_i      (key_q),
      .tok_i      (tok[i]),
      .src_o      (cell_src[i]),
      .mesg_o     (cell_mesg[i]),
      .tok_o      (tok[i+1])
    );
  end

  // Control and result register
  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    out_vld_d = out_vld_q && !out_ready_i;
    status_d  = status_q;
    osrc_d    = osrc_q;
    omesg_d   = omesg_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_SRCH) begin
            st_d = ST_SRCH;
          end else begin
            out_vld_d = 1'b1;
            status_d  = ST_OK;
            osrc_d    = 8'd0;
            omesg_d   = 32'sd0;
            if (req_type_i == REQ_ENQ) begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CntW'(1);
              end
            end else if (req_type_i == REQ_DEQ) begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                osrc_d  = cell_src[0];
                omesg_d = cell_mesg[0];
                count_d = count_q - CntW'(1);
              end
            end
          end
        end
      end
      ST_SRCH: begin
        if (tok[DEPTH].vld) begin
          st_d      = ST_IDLE;
          out_vld_d = 1'b1;
          status_d  = tok[DEPTH].found ? ST_OK : ST_NOTFOUND;
          osrc_d    = tok[DEPTH].found ? tok[DEPTH].src : 8'd0;
          omesg_d   = 32'sd0;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      count_q   <= '0;
      launch_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      count_q   <= count_d;
      launch_q  <= in_acc && (req_type_i == REQ_SRCH);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    osrc_q   <= osrc_d;
    omesg_q  <= omesg_d;
    if (in_acc && (req_type_i == REQ_SRCH)) begin
      key_q <= in_mesg_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign out_src_o   = osrc_q;
  assign out_mesg_o  = omesg_q;
  assign occupancy_o = count_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_no_accept_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SRCH) |-> !in_ready_o)
    else $error("request taken during search");

  a_token_only_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[DEPTH].vld |-> (st_q == ST_SRCH))
    else $error("search token outside search");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_enq |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("enqueue did not bump occupancy");

endmodule

### verif/tb_searchable_message_fifo_core.sv
module tb_searchable_message_fifo_core;
  import smf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = SmfDepth;
  localparam int OccW = $clog2(Depth + 1);
  localparam req_t ReqUnused = 2'd3;
  localparam int RandItems = 1600;
  localparam int CycleLimit = 1000000;
  localparam int PressureAt = 300;
  localparam int PressureLen = 500;

  typedef struct packed {
    req_t        req;
    logic [7:0]  src;
    logic [31:0] mesg;
  } request_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [31:0] mesg;
  } msg_t;

  typedef struct packed {
    status_t         status;
    logic [7:0]      src;
    logic [31:0]     mesg;
    logic [OccW-1:0] occ;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = REQ_ENQ;
  logic [7:0]         in_src = '0;
  logic signed [31:0] in_mesg = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [7:0]         out_src;
  logic signed [31:0] out_mesg;
  logic [OccW-1:0]    occupancy;

  // Stimulus, queue shadow and expected responses
  request_t  pending_reqs[$];
  msg_t      held_msgs[$];
  response_t awaited_responses[$];
  logic [31:0] recent_keys[$];

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   tx_gap = 0;
  int   rx_stall = 0;
  int   rx_hold = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  bit   pressure_done = 1'b0;
  int   responses_seen = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  // Coverage tallies
  int n_enq = 0, n_drop = 0, n_deq = 0, n_deq_empty = 0;
  int n_hit = 0, n_miss = 0, n_unused = 0, n_full_seen = 0;

  searchable_message_fifo_core #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .req_type_i (req_type),
    .in_src_i   (in_src),
    .in_mesg_i  (in_mesg),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .out_src_o  (out_src),
    .out_mesg_o (out_mesg),
    .occupancy_o(occupancy)
  );

  always #10 clk_i = ~clk_i;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Payloads: small values give duplicate keys, extremes now and then
  function automatic logic [31:0] rand_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 7);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_req(input req_t r, input logic [7:0] s, input logic [31:0] m);
    request_t item;
    item.req = r;
    item.src = s;
    item.mesg = m;
    pending_reqs.push_back(item);
    if (r == REQ_ENQ) begin
      recent_keys.push_back(m);
      if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    end
  endtask

  // Queue behavior: response for one request, shadow state updated
  function automatic response_t fifo_response(request_t item);
    response_t resp;
    msg_t      entry;
    resp = '0;
    resp.status = ST_OK;
    case (item.req)
      REQ_ENQ: begin
        if (held_msgs.size() >= Depth) begin
          resp.status = ST_FULL;
          n_drop++;
        end else begin
          entry.src = item.src;
          entry.mesg = item.mesg;
          held_msgs.push_back(entry);
          n_enq++;
          if (held_msgs.size() == Depth) n_full_seen++;
        end
      end
      REQ_DEQ: begin
        if (held_msgs.size() == 0) begin
          resp.status = ST_EMPTY;
          n_deq_empty++;
        end else begin
          entry = held_msgs.pop_front();
          resp.src = entry.src;
          resp.mesg = entry.mesg;
          n_deq++;
        end
      end
      REQ_SRCH: begin
        resp.status = ST_NOTFOUND;
        foreach (held_msgs[k]) begin
          if (held_msgs[k].mesg == item.mesg) begin
            resp.status = ST_OK;
            resp.src = held_msgs[k].src;
            break;
          end
        end
        if (resp.status == ST_OK) n_hit++;
        else n_miss++;
      end
      default: n_unused++;
    endcase
    resp.occ = OccW'(held_msgs.size());
    return resp;
  endfunction

  // Sample both handshakes, predict on input, check on output
  always @(posedge clk_i) begin : watch
    request_t  item;
    response_t want;
    response_t got;
    in_taken <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        item.req = req_type;
        item.src = in_src;
        item.mesg = in_mesg;
        awaited_responses.push_back(fifo_response(item));
      end
      if (out_valid && out_ready) begin
        responses_seen++;
        got.status = status;
        got.src = out_src;
        got.mesg = out_mesg;
        got.occ = occupancy;
        if (awaited_responses.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word status=%0d src=%0d mesg=%0d occ=%0d", $time,
                   got.status, got.src, $signed(got.mesg), got.occ);
        end else begin
          want = awaited_responses.pop_front();
          if (got != want) begin
            error_count++;
            $display("%0t: mismatch expected status=%0d src=%0d mesg=%0d occ=%0d, ",
                     $time, want.status, want.src, $signed(want.mesg), want.occ,
                     "actual status=%0d src=%0d mesg=%0d occ=%0d",
                     got.status, got.src, $signed(got.mesg), got.occ);
          end
        end
      end
    end
  end

  // Sender: hold a word until taken, then gap, then next word
  always @(negedge clk_i) begin : tx_drive
    request_t item;
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) tx_quiet = !tx_quiet;
      if (in_taken) tx_gap = tx_quiet ? 0 : pick_gap();
      if (in_valid && !in_taken) begin
        // keep offering the same word
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        item = pending_reqs.pop_front();
        req_type <= item.req;
        in_src <= item.src;
        in_mesg <= item.mesg;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the input
  always @(negedge clk_i) begin : rx_drive
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
      if (responses_seen >= PressureAt && !pressure_done) begin
        pressure_done = 1'b1;
        rx_hold = PressureLen;
      end
      if (out_taken) rx_stall = rx_quiet ? 0 : pick_gap();
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_searchable_message_fifo_core: errors");
      $finish;
    end
  end

  initial begin : run
    int          made;
    int          len;
    int          mode;
    int          r;
    int          enq_pct;
    int          deq_pct;
    logic [31:0] key;

    // Directed: empty cases, extremes, duplicate keys, unused code
    add_req(REQ_DEQ, 8'd0, 32'd0);
    add_req(REQ_SRCH, 8'd0, 32'd0);
    add_req(ReqUnused, 8'hff, 32'hffff_ffff);
    add_req(REQ_ENQ, 8'h00, 32'h8000_0000);
    add_req(REQ_ENQ, 8'hff, 32'h7fff_ffff);
    add_req(REQ_ENQ, 8'h55, 32'h0000_0000);
    add_req(REQ_ENQ, 8'haa, 32'hffff_ffff);
    add_req(REQ_ENQ, 8'h07, 32'h0000_0000);
    add_req(REQ_SRCH, 8'h00, 32'h0000_0000);
    add_req(REQ_SRCH, 8'h00, 32'h7fff_ffff);
    add_req(REQ_SRCH, 8'h00, 32'h8000_0000);
    add_req(REQ_SRCH, 8'h00, 32'd12345);
    add_req(ReqUnused, 8'h12, 32'h5a5a_5a5a);
    add_req(REQ_DEQ, 8'h00, 32'd0);
    add_req(REQ_DEQ, 8'h00, 32'd0);
    add_req(REQ_SRCH, 8'h00, 32'h0000_0000);

    // Fill burst past full so drops show up early
    for (int i = 0; i < Depth + 6; i++)
      add_req(REQ_ENQ, 8'($urandom_range(0, 255)), rand_payload());
    add_req(REQ_SRCH, 8'h00, recent_keys[recent_keys.size() - 10]);

    // Random phases: filling, draining, mixed
    made = Depth + 7;
    while (made < RandItems) begin
      len = $urandom_range(20, 140);
      mode = $urandom_range(0, 2);
      enq_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
      deq_pct = (mode == 0) ? 10 : (mode == 1) ? 60 : 35;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          add_req(ReqUnused, 8'($urandom_range(0, 255)), $urandom);
        end else if (r < 3 + enq_pct) begin
          add_req(REQ_ENQ, 8'($urandom_range(0, 255)), rand_payload());
        end else if (r < 3 + enq_pct + deq_pct) begin
          add_req(REQ_DEQ, 8'($urandom_range(0, 255)), $urandom);
        end else begin
          if (recent_keys.size() > 0 && $urandom_range(0, 99) < 70)
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
          else
            key = rand_payload();
          add_req(REQ_SRCH, 8'($urandom_range(0, 255)), key);
        end
      end
      made += len;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid || awaited_responses.size() != 0)
      @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);

    if (awaited_responses.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, awaited_responses.size());
    end

    $display("run covered %0d responses: %0d enqueues, %0d dropped when full, %0d dequeues,",
             responses_seen, n_enq, n_drop, n_deq);
    $display("  %0d dequeues on empty, %0d search hits, %0d misses, %0d unused codes, %0d fills",
             n_deq_empty, n_hit, n_miss, n_unused, n_full_seen);
    if (error_count == 0) begin
      $display("tb_searchable_message_fifo_core: clean");
    end else begin
      $display("tb_searchable_message_fifo_core: errors");
    end
    $finish;
  end

endmodule
